>>> hw/rtl/b64crc_pkg.sv
// Shared types, constants and functions for the base64 encoder with CRC-24.
// Used by the top level, the character serializer and the port checker.
package b64crc_pkg;

	localparam logic [23:0] CRC24_INIT = 24'hB704CE;
	localparam logic [23:0] CRC24_POLY = 24'h864CFB;
	localparam logic [7:0]  NL_CHAR    = 8'h0A;

	localparam int unsigned CFG_IDX_W  = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_USE_CRC      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NO_LINEFEEDS = 8'd1;

	// One complete group handed to the serializer.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic            newline;
		logic [23:0]     crc;
	} grp_t;

	// Map a six-bit code to its character of the standard alphabet.
	function automatic logic [7:0] b64_char(input logic [5:0] s);
		logic [7:0] c;
		if (s < 6'd26) begin
			c = 8'h41 + {2'b00, s};
		end else if (s < 6'd52) begin
			c = 8'h61 + {2'b00, s - 6'd26};
		end else if (s < 6'd62) begin
			c = 8'h30 + {2'b00, s - 6'd52};
		end else if (s == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

	// One byte of the OpenPGP CRC-24, most significant bit first.
	function automatic logic [23:0] crc24_byte(input logic [23:0] crc, input logic [7:0] b);
		logic [23:0] c;
		c = crc ^ {b, 16'h0000};
		for (int i = 0; i < 8; i++) begin
			if (c[23]) begin
				c = {c[22:0], 1'b0} ^ CRC24_POLY;
			end else begin
				c = {c[22:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/b64crc_serializer.sv
// Holds one finished group and sends its characters out one beat at a time.
// Depends on b64crc_pkg for the group type and the newline code.
module b64crc_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  b64crc_pkg::grp_t   grp,
	output logic               can_load,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_char,
	output logic               last_of_run,
	output logic [23:0]        running_crc
);
	import b64crc_pkg::*;

	grp_t       grp_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic       last;

	assign last = grp_q.newline ? (idx_q == 3'd4) : (idx_q == 3'd3);

	assign out_valid   = busy_q;
	assign out_char    = (idx_q == 3'd4) ? NL_CHAR : grp_q.chars[idx_q[1:0]];
	assign last_of_run = last;
	assign running_crc = grp_q.crc;

	// A new group may enter while the last beat of the current one leaves.
	assign can_load = !busy_q || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (busy_q && out_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= grp;
		end
	end

endmodule

>>> hw/rtl/base64_encoder_crc24_linewrap.sv
// Top level of the base64 encoder with OpenPGP CRC-24 and line wrapping.
// Depends on b64crc_pkg and b64crc_serializer.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-----------------------------------------
//  input    | in_valid / in_ready   | data_byte
//  output   | out_valid / out_ready | out_char, last_of_run, running_crc
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each accepted byte updates the held bytes, and the CRC when it is enabled, in the
// cycle it arrives. Every third byte loads four characters, plus a newline at the end
// of a line unless line feeds are off, into the serializer, which sends one character
// per cycle while the output is ready; the output port sets the rate. A completing byte
// waits while the previous group still has characters to send, except in the cycle its
// last one leaves. Reset clears the byte count, the line count and the configuration
// registers, and loads the CRC with its initial value.
module base64_encoder_crc24_linewrap #(
	parameter int unsigned QUADS_PER_LINE = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        out_char,
	output logic                              last_of_run,
	output logic [23:0]                       running_crc,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [b64crc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic                              cfg_data
);
	import b64crc_pkg::*;

	localparam int unsigned QW = (QUADS_PER_LINE > 1) ? $clog2(QUADS_PER_LINE) : 1;
	localparam logic [QW-1:0] QUAD_LAST = QW'(QUADS_PER_LINE - 1);

	logic          use_crc_q;
	logic          no_lf_q;
	logic [7:0]    pend0_q;
	logic [7:0]    pend1_q;
	logic [1:0]    count_q;
	logic [QW-1:0] quads_q;
	logic [23:0]   crc_q;

	logic          accept;
	logic          complete;
	logic          can_load;
	logic          wrap;
	logic [23:0]   crc_next;
	grp_t          grp;

	assign cfg_ready = 1'b1;

	assign complete = (count_q == 2'd2);
	assign in_ready = !complete || can_load;
	assign accept   = in_valid && in_ready;
	assign wrap     = (quads_q == QUAD_LAST);
	assign crc_next = use_crc_q ? crc24_byte(crc_q, data_byte) : crc_q;

	always_comb begin
		grp.chars[0] = b64_char(pend0_q[7:2]);
		grp.chars[1] = b64_char({pend0_q[1:0], pend1_q[7:4]});
		grp.chars[2] = b64_char({pend1_q[3:0], data_byte[7:6]});
		grp.chars[3] = b64_char(data_byte[5:0]);
		grp.newline  = wrap && !no_lf_q;
		grp.crc      = crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_crc_q <= 1'b0;
			no_lf_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_USE_CRC:      use_crc_q <= cfg_data;
				REG_NO_LINEFEEDS: no_lf_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			quads_q <= '0;
			crc_q   <= CRC24_INIT;
		end else if (accept) begin
			crc_q <= crc_next;
			if (complete) begin
				count_q <= 2'd0;
				quads_q <= wrap ? '0 : quads_q + QW'(1);
			end else begin
				count_q <= count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && count_q == 2'd0) begin
			pend0_q <= data_byte;
		end
		if (accept && count_q == 2'd1) begin
			pend1_q <= data_byte;
		end
	end

	b64crc_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept && complete),
		.grp         (grp),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run),
		.running_crc (running_crc)
	);

endmodule

>>> hw/rtl/b64crc_checker.sv
// Port checker for the base64 encoder with CRC-24, attached by bind.
// Depends on b64crc_pkg for the newline code and register index width.
module b64crc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [7:0]                        data_byte,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [7:0]                        out_char,
	input logic                              last_of_run,
	input logic [23:0]                       running_crc,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [b64crc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic                              cfg_data
);
	import b64crc_pkg::*;

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
			&& $stable(last_of_run) && $stable(running_crc))
		else $error("stalled result beat changed");

	// A newline always closes the run of its group.
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_char == NL_CHAR |-> last_of_run)
		else $error("newline not marked last");

	// Every beat is a base64 character or a newline.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char >= 8'h41 && out_char <= 8'h5A)
			|| (out_char >= 8'h61 && out_char <= 8'h7A)
			|| (out_char >= 8'h30 && out_char <= 8'h39)
			|| out_char == 8'h2B || out_char == 8'h2F || out_char == NL_CHAR)
		else $error("character outside the alphabet");

	// Inside one group the reported CRC stays and the next beat follows at once.
	a_grp_crc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && $stable(running_crc))
		else $error("group broken before its last beat");

endmodule

bind base64_encoder_crc24_linewrap b64crc_checker u_b64crc_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for base64_encoder_crc24_linewrap: random and corner-case
// bytes are encoded by an in-bench predictor and every output beat is compared.
// Depends on b64crc_pkg and the encoder RTL.
module tb_top;
	import b64crc_pkg::*;

	localparam int LINE_QUADS   = 16;
	localparam int IDLE_PCT     = 33;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int STALL_LIMIT  = 3000;
	localparam int NUM_CORNER   = 23;

	// Indexes that map to no register; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = REG_NO_LINEFEEDS + 8'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_TOP      = '1;

	// Groups that hit the alphabet edges: AAAA, ////, ++++, Z/a and z/0, 9/+/ then A.
	// The single-bit bytes that follow walk a one through every bit position.
	localparam logic [7:0] CORNER_BYTES [NUM_CORNER] = '{
		8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'hEF, 8'hBE,
		8'h65, 8'hAC, 8'hF4, 8'hF7, 8'hEF, 8'hC0,
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
	};

	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
		logic [23:0] crc;
	} enc_char_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           data_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           out_char;
	logic                 last_of_run;
	logic [23:0]          running_crc;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic                 cfg_data = 1'b0;

	// Predictor state and register copies.
	logic        crc_on = 1'b0;
	logic        lf_off = 1'b0;
	logic [7:0]  held [2] = '{8'h00, 8'h00};
	logic [1:0]  held_cnt = '0;
	int          line_quads = 0;
	logic [23:0] crc_acc = CRC24_INIT;

	logic [7:0] bytes_to_send [$];
	enc_char_t  chars_due [$];
	enc_char_t  want;
	int         errors = 0;
	bit         steady = 1'b0;
	int         hold_asked = 0;
	int         hold_taken = 0;
	int         hold_left = 0;

	base64_encoder_crc24_linewrap #(
		.QUADS_PER_LINE(LINE_QUADS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.last_of_run(last_of_run),
		.running_crc(running_crc),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [23:0] crc_fold(input logic [23:0] crc, input logic [7:0] b);
		logic [24:0] r;
		r = {1'b0, crc ^ {b, 16'h0000}};
		for (int k = 0; k < 8; k++) begin
			r = r << 1;
			if (r[24]) begin
				r = r ^ {1'b1, CRC24_POLY};
			end
		end
		return r[23:0];
	endfunction

	function automatic logic [7:0] sextet_ascii(input logic [5:0] s);
		logic [7:0] v;
		v = {2'b00, s};
		if (v < 8'd26) begin
			return 8'h41 + v;
		end else if (v < 8'd52) begin
			return 8'h61 + (v - 8'd26);
		end else if (v < 8'd62) begin
			return 8'h30 + (v - 8'd52);
		end else if (v == 8'd62) begin
			return 8'h2B;
		end
		return 8'h2F;
	endfunction

	// Absorbs one accepted byte and queues the characters it completes.
	function automatic void encode_byte(input logic [7:0] b);
		logic [5:0] sx [4];
		enc_char_t  c;
		int         n;
		if (crc_on) begin
			crc_acc = crc_fold(crc_acc, b);
		end
		if (held_cnt < 2'd2) begin
			held[held_cnt[0]] = b;
			held_cnt = held_cnt + 2'd1;
		end else begin
			held_cnt = '0;
			sx[0] = held[0][7:2];
			sx[1] = {held[0][1:0], held[1][7:4]};
			sx[2] = {held[1][3:0], b[7:6]};
			sx[3] = b[5:0];
			line_quads++;
			n = 4;
			if (line_quads >= LINE_QUADS) begin
				line_quads = 0;
				if (!lf_off) begin
					n = 5;
				end
			end
			for (int k = 0; k < n; k++) begin
				c.ch   = (k < 4) ? sextet_ascii(sx[k]) : NL_CHAR;
				c.last = (k == n - 1);
				c.crc  = crc_acc;
				chars_due.push_back(c);
			end
		end
	endfunction

	// Input side: one beat in flight, taken from the front of the byte queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= '0;
		end else begin
			if (in_valid && in_ready) begin
				encode_byte(data_byte);
				void'(bytes_to_send.pop_front());
			end
			if (!in_valid || in_ready) begin
				if (bytes_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid  <= 1'b1;
					data_byte <= bytes_to_send[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: random back-pressure, a long hold when asked, and the checks.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (chars_due.size() == 0) begin
					$display("%0t: unexpected beat char=%h last=%b crc=%h",
						$time, out_char, last_of_run, running_crc);
					errors++;
				end else begin
					want = chars_due.pop_front();
					if (out_char !== want.ch) begin
						$display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
						errors++;
					end
					if (last_of_run !== want.last) begin
						$display("%0t: last_of_run expected %b actual %b",
							$time, want.last, last_of_run);
						errors++;
					end
					if (running_crc !== want.crc) begin
						$display("%0t: running_crc expected %h actual %h",
							$time, want.crc, running_crc);
						errors++;
					end
				end
			end
			if (hold_left == 0 && hold_taken < hold_asked) begin
				hold_taken++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
					|| (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no beat moved for %0d cycles", $time, quiet);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_USE_CRC:      crc_on = val;
			REG_NO_LINEFEEDS: lf_off = val;
			default: ;
		endcase
	endtask

	task automatic send_random(input int count);
		int r;
		@(negedge clk);
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(9);
			if (r == 0) begin
				bytes_to_send.push_back(8'h00);
			end else if (r == 1) begin
				bytes_to_send.push_back(8'hFF);
			end else begin
				bytes_to_send.push_back(8'($urandom_range(255)));
			end
		end
	endtask

	// Returns once every byte is taken and every character checked, plus a
	// margin for a group that may still be in the serializer.
	task automatic wait_drained();
		do @(negedge clk); while (bytes_to_send.size() != 0 || chars_due.size() != 0 || in_valid);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(REG_USE_CRC, 1'b0);
		write_reg(REG_NO_LINEFEEDS, 1'b0);
		write_reg(IDX_UNMAPPED, 1'b1);
		write_reg(IDX_TOP, 1'b1);
		@(negedge clk);
		for (int k = 0; k < NUM_CORNER; k++) begin
			bytes_to_send.push_back(CORNER_BYTES[k]);
		end
		wait_drained();

		// No idling here; the long output hold makes the encoder stall its input.
		write_reg(REG_USE_CRC, 1'b1);
		@(negedge clk);
		steady = 1'b1;
		hold_asked++;
		send_random(60);
		wait_drained();
		steady = 1'b0;

		write_reg(REG_NO_LINEFEEDS, 1'b1);
		send_random(45);
		wait_drained();

		write_reg(REG_USE_CRC, 1'b0);
		send_random(45);
		wait_drained();

		write_reg(REG_USE_CRC, 1'b1);
		write_reg(REG_NO_LINEFEEDS, 1'b0);
		send_random(40);
		wait_drained();

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
